/* design/assert_macros.svh */
// Assertion helpers for the allocator; empty when synthesizing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define NFTA_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define NFTA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define NFTA_ASSERT_SAME(lbl, ante, cons, msg)
`define NFTA_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

/* design/nfta_pkg.sv */
// ----------------------------------------------------------------------------
// nfta_pkg
// Widths, codes and controller/datapath types of the next-fit allocator.
// ----------------------------------------------------------------------------
package nfta_pkg;

  localparam int ARENA_WORDS = 8192;
  localparam int AW          = 13;   // header address
  localparam int PW          = 14;   // walk pointer, can hold the arena end
  localparam int HW          = 15;   // signed header word
  localparam int SW          = 15;   // request size in words
  localparam int STW         = 14;   // lap step counter
  localparam int BW          = 16;   // request bytes
  localparam int HDW         = 14;   // free handle

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_OOM     = 2'd1,
    ST_BADPTR  = 2'd2,
    ST_CORRUPT = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_RD_P,
    CMD_RD_Q,
    CMD_ADV_P,
    CMD_SPLIT1,
    CMD_SPLIT2,
    CMD_MERGE_INIT,
    CMD_Q_INIT,
    CMD_Q_ADV,
    CMD_MERGE_WR,
    CMD_MERGE_SKIP,
    CMD_ROVER0,
    CMD_FREE_RD,
    CMD_FREE_WR
  } cmd_t;

  typedef struct packed {
    logic          action;
    logic          handle_null;
    logic          handle_big;
    logic          hdr_zero;
    logic          hdr_pos;
    logic          hdr_neg;
    logic          mag_bad;
    logic          fits;
    logic          exact;
    logic          p_is_rover;
    logic          steps_over;
    logic          p_done;
    logic          q_done;
    logic          q_bad;
    logic [AW-1:0] offset;
  } dp_status_t;

endpackage

/* design/nfta_req_if.sv */
// ----------------------------------------------------------------------------
// nfta_req_if
// Request channel: allocate or free transaction.
// ----------------------------------------------------------------------------
interface nfta_req_if;
  import nfta_pkg::*;
  logic           valid;
  logic           ready;
  logic           action;
  logic [BW-1:0]  request_bytes;
  logic [HDW-1:0] handle;

  modport source (output valid, action, request_bytes, handle, input ready);
  modport sink   (input valid, action, request_bytes, handle, output ready);
endinterface

/* design/nfta_rsp_if.sv */
// ----------------------------------------------------------------------------
// nfta_rsp_if
// Result channel: status and granted payload offset.
// ----------------------------------------------------------------------------
interface nfta_rsp_if;
  import nfta_pkg::*;
  logic          valid;
  logic          ready;
  logic [1:0]    status;
  logic [AW-1:0] block_offset;

  modport source (output valid, status, block_offset, input ready);
  modport sink   (input valid, status, block_offset, output ready);
endinterface

/* design/nfta_datapath.sv */
// ----------------------------------------------------------------------------
// nfta_datapath
// Header memory, walk pointers, rover and the header compares.
// ----------------------------------------------------------------------------
module nfta_datapath
  import nfta_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  input  cmd_t           cmd,
  input  logic           in_action,
  input  logic [BW-1:0]  in_request_bytes,
  input  logic [HDW-1:0] in_handle,
  output dp_status_t     dp
);

  logic signed [HW-1:0] mem [ARENA_WORDS];
  logic signed [HW-1:0] rd_q_r;
  logic                 rd_unset_r;
  logic                 w0_set_r;

  logic [PW-1:0]  p_r, p_nxt;
  logic [PW-1:0]  q_r, q_nxt;
  logic [AW-1:0]  rover_r, rover_nxt;
  logic [STW-1:0] steps_r, steps_nxt;
  logic [SW-1:0]  size_r, size_nxt;
  logic [HDW-1:0] handle_r, handle_nxt;
  logic           action_r, action_nxt;
  logic [AW-1:0]  off_r, off_nxt;

  logic signed [HW-1:0] hdr;
  logic [HW-1:0]        mag;
  logic [15:0]          room_p, room_q;
  logic [15:0]          size_p1;
  logic [15:0]          p_sum;
  logic                 rd_en, wr_en;
  logic [AW-1:0]        rd_addr, wr_addr;
  logic signed [HW-1:0] wr_data;
  logic [AW-1:0]        free_addr;

  // word 0 reads as the full arena until its first write
  assign hdr     = rd_unset_r ? HW'(ARENA_WORDS) : rd_q_r;
  assign mag     = hdr[HW-1] ? (~hdr + 1'b1) : hdr;
  assign room_p  = 16'(ARENA_WORDS) - 16'(p_r);
  assign room_q  = 16'(ARENA_WORDS) - 16'(q_r);
  assign size_p1 = 16'(size_r) + 16'd1;
  assign p_sum   = 16'(p_r) + 16'(mag);
  assign free_addr = AW'(handle_r - 1'b1);

  always_comb begin
    dp.action      = action_r;
    dp.handle_null = (handle_r == '0);
    dp.handle_big  = (15'(handle_r) > 15'(ARENA_WORDS));
    dp.hdr_zero    = (hdr == '0);
    dp.hdr_pos     = !hdr[HW-1] && (hdr != '0);
    dp.hdr_neg     = hdr[HW-1];
    dp.mag_bad     = (16'(mag) > room_p);
    dp.fits        = (mag > size_r);
    dp.exact       = (16'(mag) == size_p1);
    dp.p_is_rover  = (p_r == PW'(rover_r));
    dp.steps_over  = (steps_r > STW'(ARENA_WORDS));
    dp.p_done      = (15'(p_r) >= 15'(ARENA_WORDS));
    dp.q_done      = (15'(q_r) >= 15'(ARENA_WORDS));
    dp.q_bad       = (16'(mag) > room_q);
    dp.offset      = off_r;
  end

  always_comb begin
    p_nxt      = p_r;
    q_nxt      = q_r;
    rover_nxt  = rover_r;
    steps_nxt  = steps_r;
    size_nxt   = size_r;
    handle_nxt = handle_r;
    action_nxt = action_r;
    off_nxt    = off_r;
    rd_en      = 1'b0;
    rd_addr    = p_r[AW-1:0];
    wr_en      = 1'b0;
    wr_addr    = p_r[AW-1:0];
    wr_data    = -hdr;
    unique case (cmd)
      CMD_LOAD: begin
        action_nxt = in_action;
        handle_nxt = in_handle;
        size_nxt   = SW'((17'(in_request_bytes) + 17'd3) >> 2);
        p_nxt      = PW'(rover_r);
        steps_nxt  = '0;
      end
      CMD_RD_P: rd_en = 1'b1;
      CMD_RD_Q: begin
        rd_en   = 1'b1;
        rd_addr = q_r[AW-1:0];
      end
      CMD_ADV_P: begin
        p_nxt     = (p_sum == 16'(ARENA_WORDS)) ? '0 : PW'(p_sum);
        steps_nxt = steps_r + 1'b1;
      end
      CMD_SPLIT1: begin
        wr_en     = 1'b1;
        wr_data   = dp.exact ? -hdr : -HW'(size_p1);
        rover_nxt = p_r[AW-1:0];
        off_nxt   = AW'(p_r + 1'b1);
      end
      CMD_SPLIT2: begin
        wr_en   = 1'b1;
        wr_addr = AW'(16'(p_r) + size_p1);
        wr_data = HW'(16'(mag) - size_p1);
      end
      CMD_MERGE_INIT: p_nxt = '0;
      CMD_Q_INIT:     q_nxt = PW'(p_sum);
      CMD_Q_ADV:      q_nxt = PW'(16'(q_r) + 16'(mag));
      CMD_MERGE_WR: begin
        wr_en   = 1'b1;
        wr_data = HW'(q_r - p_r);
        p_nxt   = q_r;
      end
      CMD_MERGE_SKIP: p_nxt = PW'(p_sum);
      CMD_ROVER0: begin
        rover_nxt = '0;
        p_nxt     = '0;
        steps_nxt = '0;
      end
      CMD_FREE_RD: begin
        rd_en   = 1'b1;
        rd_addr = free_addr;
      end
      CMD_FREE_WR: begin
        wr_en   = 1'b1;
        wr_addr = free_addr;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q_r     <= mem[rd_addr];
      rd_unset_r <= (rd_addr == '0) && !w0_set_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w0_set_r <= 1'b0;
      rover_r  <= '0;
    end else begin
      if (wr_en && wr_addr == '0) begin
        w0_set_r <= 1'b1;
      end
      rover_r <= rover_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p_r      <= p_nxt;
    q_r      <= q_nxt;
    steps_r  <= steps_nxt;
    size_r   <= size_nxt;
    handle_r <= handle_nxt;
    action_r <= action_nxt;
    off_r    <= off_nxt;
  end

endmodule

/* design/nfta_ctrl.sv */
// ----------------------------------------------------------------------------
// nfta_ctrl
// Sequencer for search laps, merge pass and free; holds the result register.
// ----------------------------------------------------------------------------
module nfta_ctrl
  import nfta_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output status_t       out_status,
  output logic [AW-1:0] out_offset,
  input  dp_status_t    dp,
  output cmd_t          cmd
);

  typedef enum logic [11:0] {
    S_IDLE     = 12'b000000000001,
    S_DISPATCH = 12'b000000000010,
    S_RD       = 12'b000000000100,
    S_EV       = 12'b000000001000,
    S_SPLIT2   = 12'b000000010000,
    S_M_RD     = 12'b000000100000,
    S_M_EV     = 12'b000001000000,
    S_MQ_CHK   = 12'b000010000000,
    S_MQ_EV    = 12'b000100000000,
    S_F_CHK    = 12'b001000000000,
    S_F_EV     = 12'b010000000000,
    S_DONE     = 12'b100000000000
  } state_t;

  state_t        state_r, state_nxt;
  logic          first_r, first_nxt;
  logic          second_r, second_nxt;
  status_t       res_r, res_nxt;
  logic          out_valid_r, out_valid_nxt;
  status_t       out_status_r, out_status_nxt;
  logic [AW-1:0] out_offset_r, out_offset_nxt;

  assign in_ready   = (state_r == S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_offset = out_offset_r;

  always_comb begin
    state_nxt      = state_r;
    first_nxt      = first_r;
    second_nxt     = second_r;
    res_nxt        = res_r;
    cmd            = CMD_NONE;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_offset_nxt = out_offset_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd        = CMD_LOAD;
          first_nxt  = 1'b1;
          second_nxt = 1'b0;
          state_nxt  = S_DISPATCH;
        end
      end
      S_DISPATCH: state_nxt = dp.action ? S_F_CHK : S_RD;
      S_RD: begin
        cmd       = CMD_RD_P;
        state_nxt = S_EV;
      end
      S_EV: begin
        // lap-end checks only apply after the walk has moved
        priority if (!first_r && dp.hdr_zero) begin
          res_nxt   = ST_CORRUPT;
          state_nxt = S_DONE;
        end else if (!first_r && dp.p_is_rover) begin
          if (second_r) begin
            res_nxt   = ST_OOM;
            state_nxt = S_DONE;
          end else begin
            cmd       = CMD_MERGE_INIT;
            state_nxt = S_M_RD;
          end
        end else if ((!first_r && dp.steps_over) || dp.hdr_zero || dp.mag_bad) begin
          res_nxt   = ST_CORRUPT;
          state_nxt = S_DONE;
        end else if (dp.hdr_pos && dp.fits) begin
          cmd       = CMD_SPLIT1;
          res_nxt   = ST_OK;
          state_nxt = dp.exact ? S_DONE : S_SPLIT2;
        end else begin
          cmd       = CMD_ADV_P;
          first_nxt = 1'b0;
          state_nxt = S_RD;
        end
      end
      S_SPLIT2: begin
        cmd       = CMD_SPLIT2;
        state_nxt = S_DONE;
      end
      S_M_RD: begin
        if (dp.p_done) begin
          cmd        = CMD_ROVER0;
          first_nxt  = 1'b1;
          second_nxt = 1'b1;
          state_nxt  = S_RD;
        end else begin
          cmd       = CMD_RD_P;
          state_nxt = S_M_EV;
        end
      end
      S_M_EV: begin
        priority if (dp.hdr_zero || dp.mag_bad) begin
          res_nxt   = ST_CORRUPT;
          state_nxt = S_DONE;
        end else if (dp.hdr_pos) begin
          cmd       = CMD_Q_INIT;
          state_nxt = S_MQ_CHK;
        end else begin
          cmd       = CMD_MERGE_SKIP;
          state_nxt = S_M_RD;
        end
      end
      S_MQ_CHK: begin
        if (dp.q_done) begin
          cmd       = CMD_MERGE_WR;
          state_nxt = S_M_RD;
        end else begin
          cmd       = CMD_RD_Q;
          state_nxt = S_MQ_EV;
        end
      end
      S_MQ_EV: begin
        priority if (dp.hdr_pos && dp.q_bad) begin
          res_nxt   = ST_CORRUPT;
          state_nxt = S_DONE;
        end else if (dp.hdr_pos) begin
          cmd       = CMD_Q_ADV;
          state_nxt = S_MQ_CHK;
        end else begin
          cmd       = CMD_MERGE_WR;
          state_nxt = S_M_RD;
        end
      end
      S_F_CHK: begin
        priority if (dp.handle_null) begin
          res_nxt   = ST_OK;
          state_nxt = S_DONE;
        end else if (dp.handle_big) begin
          res_nxt   = ST_BADPTR;
          state_nxt = S_DONE;
        end else begin
          cmd       = CMD_FREE_RD;
          state_nxt = S_F_EV;
        end
      end
      S_F_EV: begin
        if (dp.hdr_neg) begin
          cmd     = CMD_FREE_WR;
          res_nxt = ST_OK;
        end else begin
          res_nxt = ST_BADPTR;
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_r;
          out_offset_nxt = (res_r == ST_OK && !dp.action) ? dp.offset : '0;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    first_r      <= first_nxt;
    second_r     <= second_nxt;
    res_r        <= res_nxt;
    out_status_r <= out_status_nxt;
    out_offset_r <= out_offset_nxt;
  end

endmodule

/* design/next_fit_tag_allocator.sv */
// A free checks the handle, then reads and rewrites its header; a null or out-of-range handle
// ends after the check. An allocate walks the search lap(s), with a split write when the block
// found is larger than asked. A failed lap adds the merge pass over all headers, then restarts
// the lap from word 0.
// Throughput: one transaction at a time; the walk is bound by the single header memory port.
// Reset (synchronous, rst_n low): rover to 0, word 0 reads as the full arena, no result.
// ----------------------------------------------------------------------------
// next_fit_tag_allocator
// Next-fit boundary-tag allocator over a fixed word arena with merge on failure.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module next_fit_tag_allocator
  import nfta_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  nfta_req_if.sink   in_ch,
  nfta_rsp_if.source out_ch
);

  cmd_t       cmd;
  dp_status_t dp;
  status_t    out_status;

  nfta_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_status (out_status),
    .out_offset (out_ch.block_offset),
    .dp         (dp),
    .cmd        (cmd)
  );

  nfta_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_action        (in_ch.action),
    .in_request_bytes (in_ch.request_bytes),
    .in_handle        (in_ch.handle),
    .dp               (dp)
  );

  assign out_ch.status = 2'(out_status);

  `NFTA_ASSERT_NEXT(a_one_at_a_time, in_ch.valid && in_ch.ready, !in_ch.ready, "accepted while busy")
  `NFTA_ASSERT_SAME(a_fail_no_offset, out_ch.valid && out_ch.status != 2'(ST_OK), out_ch.block_offset == '0, "offset on failure")
  `NFTA_ASSERT_NEXT(a_no_instant_result, in_ch.valid && in_ch.ready && !out_ch.valid, !out_ch.valid, "result too early")

endmodule
